// File: src/qph_pkg.sv
// Shared constants, codes and types for the quadratic probe hash set.
// Used by the channel interfaces, the modulo unit and the top level.
package qph_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BITS    = 31;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // slot counts and sizes up to TABLE_DEPTH
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(1021);
  localparam logic [CFG_W-1:0] MAX_KEYS_RST   = CFG_W'(512);

  // modulo unit: dividend bits consumed per cycle
  localparam int MOD_RADIX_BITS = 4;
  localparam int MOD_STEPS      = (KEY_BITS + MOD_RADIX_BITS - 1) / MOD_RADIX_BITS;
  localparam int MOD_PAD        = MOD_STEPS * MOD_RADIX_BITS;
  localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEYS   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_LIMIT   = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] rem;
  } mod_res_t;

endpackage

// File: src/qph_if.sv
// Valid/ready channel interfaces for the quadratic probe hash set.
// Depends on qph_pkg for the field widths.
interface qph_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [qph_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface qph_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [1:0]                status;
  logic [qph_pkg::CFG_W-1:0] key_total;

  modport source (output valid, output found, output status, output key_total, input ready);
  modport sink   (input valid, input found, input status, input key_total, output ready);
endinterface

// File: src/qph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/qph_mod.sv
// Multi-cycle key mod table-size unit, MOD_RADIX_BITS remainder steps a cycle.
// Depends on qph_pkg.
module qph_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [qph_pkg::KEY_BITS-1:0] dividend,
  input  logic [qph_pkg::SIZE_W-1:0]   divisor,
  output qph_pkg::mod_res_t            res
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [qph_pkg::MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [qph_pkg::MOD_PAD-1:0]   sh_r, sh_nxt;
  logic [qph_pkg::SIZE_W-1:0]    rem_r, rem_nxt;
  logic [qph_pkg::SIZE_W:0]      part;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    part     = {1'b0, rem_r};
    // restoring remainder, one dividend bit per inner step
    for (int i = 0; i < qph_pkg::MOD_RADIX_BITS; i++) begin
      part = {part[qph_pkg::SIZE_W-1:0], sh_r[qph_pkg::MOD_PAD-1-i]};
      if (part >= {1'b0, divisor}) begin
        part = part - {1'b0, divisor};
      end
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = qph_pkg::MOD_PAD'(dividend);
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = part[qph_pkg::SIZE_W-1:0];
      sh_nxt  = sh_r << qph_pkg::MOD_RADIX_BITS;
      cnt_nxt = cnt_r + qph_pkg::MOD_CNT_W'(1);
      if (cnt_r == qph_pkg::MOD_CNT_W'(qph_pkg::MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.rem  = rem_r[qph_pkg::ADDR_W-1:0];

endmodule

// File: src/quadratic_probe_hash_set.sv
// Hash set of positive keys, open addressing with quadratic probing.
// Flow: the key is reduced by the modulo unit, then each probe reads one slot and checks
// it, and a hit or miss goes to the reply register; key zero skips straight to the reply.
// Throughput: one item at a time; the next item is taken the cycle after the result
// is loaded into the output register.
// Reset: a clearing pass zeroes all TABLE_DEPTH (1024) slots of the slot memory;
module quadratic_probe_hash_set (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [qph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qph_pkg::CFG_W-1:0]     cfg_wdata,
  qph_in_if.sink                        in_ch,
  qph_out_if.source                     out_ch
);
  // no item is accepted during the clearing pass, configuration writes are taken.

  qph_pkg::state_t             state_r, state_nxt;
  logic [qph_pkg::CFG_W-1:0]   tsize_r, maxk_r, count_r, count_nxt;
  logic [qph_pkg::SIZE_W-1:0]  s_use;
  logic [qph_pkg::ADDR_W-1:0]  clr_r, clr_nxt;
  logic [qph_pkg::ADDR_W-1:0]  slot_r, slot_nxt, d_r, d_nxt;
  logic [qph_pkg::SIZE_W-1:0]  j_r, j_nxt;
  logic                        cmd_r, cmd_nxt;
  logic [qph_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic                        res_found_r, res_found_nxt;
  qph_pkg::status_t            res_status_r, res_status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_found_nxt;
  qph_pkg::status_t            out_status_r, out_status_nxt;
  logic [qph_pkg::CFG_W-1:0]   out_total_r, out_total_nxt;

  logic                        mod_start;
  qph_pkg::mod_res_t           mod_res;
  logic                        ram_we;
  logic [qph_pkg::ADDR_W-1:0]  ram_waddr;
  logic [qph_pkg::KEY_BITS-1:0] ram_wdata, ram_rdata;
  logic [qph_pkg::SIZE_W-1:0]  slot_sum, d_sum;
  logic                        in_acc;

  // clamp the table size to 2 .. TABLE_DEPTH
  always_comb begin
    if (tsize_r < qph_pkg::CFG_W'(2)) begin
      s_use = qph_pkg::SIZE_W'(2);
    end else if (int'(tsize_r) > qph_pkg::TABLE_DEPTH) begin
      s_use = qph_pkg::SIZE_W'(qph_pkg::TABLE_DEPTH);
    end else begin
      s_use = qph_pkg::SIZE_W'(tsize_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= qph_pkg::TABLE_SIZE_RST;
      maxk_r  <= qph_pkg::MAX_KEYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qph_pkg::CFG_TABLE_SIZE: tsize_r <= cfg_wdata;
        qph_pkg::CFG_MAX_KEYS:   maxk_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  qph_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_ch.key),
    .divisor  (s_use),
    .res      (mod_res)
  );

  qph_ram #(
    .WIDTH (qph_pkg::KEY_BITS),
    .DEPTH (qph_pkg::TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == qph_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // next probe: j*j grows by 2j+1; both sums stay below 2*size
  assign slot_sum = {1'b0, slot_r} + {1'b0, d_r};
  assign d_sum    = {1'b0, d_r} + qph_pkg::SIZE_W'(2);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    slot_nxt       = slot_r;
    d_nxt          = d_r;
    j_nxt          = j_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    mod_start      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    ram_wdata      = key_r;

    unique case (state_r)
      qph_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + qph_pkg::ADDR_W'(1);
        if (clr_r == qph_pkg::ADDR_W'(qph_pkg::TABLE_DEPTH - 1)) begin
          state_nxt = qph_pkg::ST_IDLE;
        end
      end
      qph_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_ch.cmd;
          key_nxt = in_ch.key;
          if (in_ch.key == '0) begin
            // key zero is never stored
            res_found_nxt  = 1'b0;
            res_status_nxt = qph_pkg::STAT_DONE;
            state_nxt      = qph_pkg::ST_RESP;
          end else begin
            mod_start = 1'b1;
            state_nxt = qph_pkg::ST_HASH;
          end
        end
      end
      qph_pkg::ST_HASH: begin
        if (mod_res.done) begin
          slot_nxt  = mod_res.rem;
          d_nxt     = qph_pkg::ADDR_W'(1);
          j_nxt     = '0;
          state_nxt = qph_pkg::ST_READ;
        end
      end
      qph_pkg::ST_READ: begin
        state_nxt = qph_pkg::ST_CHECK;
      end
      qph_pkg::ST_CHECK: begin
        priority if (ram_rdata == key_r) begin
          res_found_nxt  = 1'b1;
          res_status_nxt = (cmd_r == qph_pkg::CMD_INSERT) ? qph_pkg::STAT_PRESENT
                                                          : qph_pkg::STAT_DONE;
          state_nxt      = qph_pkg::ST_RESP;
        end else if (ram_rdata == '0 ||
                     (j_r + qph_pkg::SIZE_W'(1)) == s_use) begin
          state_nxt      = qph_pkg::ST_RESP;
          res_found_nxt  = 1'b0;
          res_status_nxt = qph_pkg::STAT_DONE;
          if (cmd_r == qph_pkg::CMD_INSERT) begin
            priority if (count_r >= maxk_r) begin
              res_status_nxt = qph_pkg::STAT_LIMIT;
            end else if (ram_rdata != '0) begin
              res_status_nxt = qph_pkg::STAT_FULL;
            end else begin
              ram_we        = 1'b1;
              count_nxt     = count_r + qph_pkg::CFG_W'(1);
              res_found_nxt = 1'b1;
            end
          end
        end else begin
          // advance to the next slot of the probe sequence
          slot_nxt  = (slot_sum >= s_use) ? qph_pkg::ADDR_W'(slot_sum - s_use)
                                          : qph_pkg::ADDR_W'(slot_sum);
          d_nxt     = (d_sum >= s_use) ? qph_pkg::ADDR_W'(d_sum - s_use)
                                       : qph_pkg::ADDR_W'(d_sum);
          j_nxt     = j_r + qph_pkg::SIZE_W'(1);
          state_nxt = qph_pkg::ST_READ;
        end
      end
      qph_pkg::ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          out_total_nxt  = count_r;
          state_nxt      = qph_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qph_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qph_pkg::ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r       <= slot_nxt;
    d_r          <= d_nxt;
    j_r          <= j_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.key_total = out_total_r;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for quadratic_probe_hash_set: drives insert and lookup
// items over valid/ready channels and checks every reply against an internal model.
// Depends on qph_pkg and the channel interfaces qph_in_if / qph_out_if.
module testbench;

  typedef struct packed {
    logic                      found;
    qph_pkg::status_t          status;
    logic [qph_pkg::CFG_W-1:0] key_total;
  } set_reply_t;

  class probe_set_board;
    bit [qph_pkg::KEY_BITS-1:0] slot_keys [qph_pkg::TABLE_DEPTH];
    int unsigned                keys_held;
    bit [qph_pkg::CFG_W-1:0]    size_reg;
    bit [qph_pkg::CFG_W-1:0]    limit_reg;
    set_reply_t                 awaited_replies [$];
    int unsigned                mismatches;

    function new();
      foreach (slot_keys[i]) slot_keys[i] = '0;
      keys_held  = 0;
      size_reg   = qph_pkg::TABLE_SIZE_RST;
      limit_reg  = qph_pkg::MAX_KEYS_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [qph_pkg::CFG_IDX_W-1:0] idx,
                            bit [qph_pkg::CFG_W-1:0] value);
      if (idx == qph_pkg::CFG_TABLE_SIZE) size_reg = value;
      else limit_reg = value;
    endfunction

    function int unsigned span_in_use();
      if (size_reg < 2) return 2;
      if (size_reg > qph_pkg::TABLE_DEPTH) return qph_pkg::TABLE_DEPTH;
      return 32'(size_reg);
    endfunction

    // walk the probe sequence and apply an insert to the slot copy
    function set_reply_t probe_reply(logic cmd, bit [qph_pkg::KEY_BITS-1:0] key);
      set_reply_t  r;
      int unsigned span, home, slot, empty_at;
      bit          empty_seen;
      r          = '{found: 1'b0, status: qph_pkg::STAT_DONE, key_total: '0};
      empty_seen = 1'b0;
      empty_at   = 0;
      span       = span_in_use();
      if (key != 0) begin
        home = 32'(key) % span;
        for (int unsigned j = 0; j < span; j++) begin
          slot = (home + j * j) % span;
          if (slot_keys[slot] == key) begin
            r.found = 1'b1;
            break;
          end
          if (slot_keys[slot] == 0) begin
            empty_seen = 1'b1;
            empty_at   = slot;
            break;
          end
        end
        if (cmd == qph_pkg::CMD_INSERT) begin
          if (r.found) r.status = qph_pkg::STAT_PRESENT;
          else if (keys_held >= limit_reg) r.status = qph_pkg::STAT_LIMIT;
          else if (!empty_seen) r.status = qph_pkg::STAT_FULL;
          else begin
            slot_keys[empty_at] = key;
            keys_held++;
            r.found = 1'b1;
          end
        end
      end
      r.key_total = keys_held[qph_pkg::CFG_W-1:0];
      return r;
    endfunction

    function void note_request(logic cmd, bit [qph_pkg::KEY_BITS-1:0] key);
      awaited_replies.insert(awaited_replies.size(), probe_reply(cmd, key));
    endfunction

    function void check_reply(logic found, logic [1:0] status,
                              logic [qph_pkg::CFG_W-1:0] total);
      set_reply_t exp;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply with nothing pending: found %0d status %0d key_total %0d",
                 $time, found, status, total);
        return;
      end
      exp = awaited_replies.pop_front();
      if (found !== exp.found) begin
        mismatches++;
        $display("%0t: found expected %0d actual %0d", $time, exp.found, found);
      end
      if (status !== exp.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
      end
      if (total !== exp.key_total) begin
        mismatches++;
        $display("%0t: key_total expected %0d actual %0d", $time, exp.key_total, total);
      end
    endfunction
  endclass

  localparam int QUIET_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 1300;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [qph_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [qph_pkg::CFG_W-1:0]     cfg_wdata;

  qph_in_if  in_ch ();
  qph_out_if out_ch ();

  quadratic_probe_hash_set uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  probe_set_board             board = new();
  bit [qph_pkg::KEY_BITS-1:0] used_keys [$];
  int unsigned                send_gap_pct;
  int unsigned                sink_stall_pct;
  int unsigned                quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reply side: check, stall at random, count cycles with no handshake
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_reply(out_ch.found, out_ch.status, out_ch.key_total);
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic set_idle_mode(int mode);
    case (mode)
      1: begin send_gap_pct = 46; sink_stall_pct = 0; end
      2: begin send_gap_pct = 0; sink_stall_pct = 46; end
      3: begin send_gap_pct = 23; sink_stall_pct = 23; end
      default: begin send_gap_pct = 0; sink_stall_pct = 0; end
    endcase
  endtask

  task automatic send_item(logic cmd, bit [qph_pkg::KEY_BITS-1:0] key);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.key   <= key;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(cmd, key);
    if (cmd == qph_pkg::CMD_INSERT && key != 0 && used_keys.size() < 2000)
      used_keys.insert(used_keys.size(), key);
  endtask

  // hold the sender until every reply is back
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.awaited_replies.size() != 0);
  endtask

  task automatic program_table(bit [qph_pkg::CFG_W-1:0] size,
                               bit [qph_pkg::CFG_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= qph_pkg::CFG_TABLE_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    board.write_reg(qph_pkg::CFG_TABLE_SIZE, size);
    cfg_index <= qph_pkg::CFG_MAX_KEYS;
    cfg_wdata <= limit;
    @(posedge clk);
    board.write_reg(qph_pkg::CFG_MAX_KEYS, limit);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [qph_pkg::KEY_BITS-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40 && used_keys.size() > 0) return used_keys[$urandom_range(used_keys.size() - 1)];
    if (r < 70) return qph_pkg::KEY_BITS'($urandom_range(64, 1));
    if (r < 95) return qph_pkg::KEY_BITS'($urandom());
    if (r < 97) return '0;
    return '1;
  endfunction

  initial begin
    int unsigned             sent, phase, span, n;
    bit [qph_pkg::CFG_W-1:0] size, limit;
    int unsigned             small_primes [10];
    small_primes   = '{2, 3, 5, 7, 11, 13, 17, 31, 61, 127};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = qph_pkg::CMD_INSERT;
    in_ch.key      = '0;
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, key zero, extremes, duplicates
    send_item(qph_pkg::CMD_LOOKUP, '0);
    send_item(qph_pkg::CMD_INSERT, '0);
    send_item(qph_pkg::CMD_INSERT, 1021);
    send_item(qph_pkg::CMD_INSERT, '1);
    send_item(qph_pkg::CMD_INSERT, '1);
    send_item(qph_pkg::CMD_LOOKUP, 1021);
    send_item(qph_pkg::CMD_LOOKUP, 1);
    // shrink the table with keys held, limit already reached
    drain_replies();
    program_table(7, 2);
    send_item(qph_pkg::CMD_LOOKUP, 1021);
    send_item(qph_pkg::CMD_INSERT, 14);
    // size below range acts as two, no keys allowed
    drain_replies();
    program_table(0, 0);
    send_item(qph_pkg::CMD_LOOKUP, 2);
    send_item(qph_pkg::CMD_INSERT, 3);
    send_item(qph_pkg::CMD_INSERT, 1021);
    // fill every slot reachable from home zero, then overflow
    drain_replies();
    program_table(7, 2047);
    send_item(qph_pkg::CMD_INSERT, 7);
    send_item(qph_pkg::CMD_INSERT, 14);
    send_item(qph_pkg::CMD_INSERT, 21);
    send_item(qph_pkg::CMD_INSERT, 28);
    send_item(qph_pkg::CMD_INSERT, 35);
    send_item(qph_pkg::CMD_LOOKUP, 35);
    send_item(qph_pkg::CMD_LOOKUP, 28);
    // limit and no free slot at once
    drain_replies();
    program_table(7, qph_pkg::CFG_W'(board.keys_held));
    send_item(qph_pkg::CMD_INSERT, 42);
    // size above range acts as the full depth
    drain_replies();
    program_table(2047, 1024);
    send_item(qph_pkg::CMD_INSERT, 1024);
    send_item(qph_pkg::CMD_INSERT, 2047);
    send_item(qph_pkg::CMD_LOOKUP, 1024);

    sent  = 0;
    phase = 1;
    while (sent < RANDOM_ITEMS) begin
      drain_replies();
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: size = qph_pkg::CFG_W'(small_primes[$urandom_range(9)]);
        6, 7:             size = qph_pkg::CFG_W'($urandom_range(256, 2));
        default: begin
          case ($urandom_range(4))
            0: size = 1021;
            1: size = 1024;
            2: size = 2047;
            3: size = qph_pkg::CFG_W'($urandom_range(1));
            default: size = qph_pkg::CFG_W'($urandom_range(1024, 257));
          endcase
        end
      endcase
      case ($urandom_range(3))
        0: limit = 2047;
        1: limit = qph_pkg::CFG_W'(board.keys_held + $urandom_range(40));
        2: limit = qph_pkg::CFG_W'($urandom_range(1024));
        default: limit = qph_pkg::CFG_W'(board.keys_held);
      endcase
      program_table(size, limit);
      set_idle_mode(phase % 4);
      span = board.span_in_use();
      // keep long probe walks rare
      n = (span > 256) ? 40 : 170;
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(99) == 0) drain_replies();
        send_item(1'($urandom_range(1)), pick_key());
        sent++;
      end
      phase++;
    end

    drain_replies();
    repeat (50) @(posedge clk);
    if (board.mismatches == 0 && board.awaited_replies.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
